// ===== rtl/core/bba_pkg.sv =====
// shared types and constants for the buddy block allocator
// no dependencies
`timescale 1ns / 1ps
package bba_pkg;
   localparam int PoolBytes   = 65536;
   localparam int MinBlock    = 32;
   localparam int HeaderBytes = 16;
   localparam int NumSlots    = PoolBytes / MinBlock;
   localparam int SlotBits    = $clog2(NumSlots);
   localparam int OrderBits   = 4;
   localparam int MinShift    = $clog2(MinBlock);
   localparam logic [OrderBits-1:0] TopOrder = OrderBits'(SlotBits);

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OOM = 2'd1;
   localparam logic [1:0] ST_BAD = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [15:0] elem_size;
      logic [15:0] item_count;
      logic [15:0] address;
   } req_type;

   typedef struct packed {
      logic [15:0] data_address;
      logic [1:0]  status;
   } rsp_type;

   // one table slot: order, start mark, free mark
   typedef struct packed {
      logic [OrderBits-1:0] order;
      logic                 start;
      logic                 free;
   } slot_type;

   // table port between controller and memory
   typedef struct packed {
      logic                 rd_en;
      logic [SlotBits-1:0]  rd_addr;
      logic                 wr_en;
      logic [SlotBits-1:0]  wr_addr;
      slot_type             wr_data;
   } tbl_cmd_type;
endpackage

// ===== rtl/core/bba_table.sv =====
// block table memory, one read and one write port, registered read
// depends on bba_pkg
`timescale 1ns / 1ps
module bba_table
   import bba_pkg::*;
(
   input  logic        clock,
   input  tbl_cmd_type cmd,
   output slot_type    rd_data
);
   slot_type mem [NumSlots];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data <= mem[cmd.rd_addr];
      end
   end
endmodule

// ===== rtl/core/bba_need.sv =====
// request size unit: need = elem_size * item_count + header, registered
// depends on bba_pkg
`timescale 1ns / 1ps
module bba_need
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        load,
   input  logic [15:0] elem_size,
   input  logic [15:0] item_count,
   output logic [32:0] need
);
   logic [32:0] need_ff;
   logic [32:0] need_in;

   assign need_in = 33'(elem_size * item_count) + 33'(HeaderBytes);

   always_ff @(posedge clock) begin
      if (load) begin
         need_ff <= need_in;
      end
   end
   assign need = need_ff;
endmodule

// ===== rtl/core/bba_ctrl.sv =====
// sequencer: clearing pass, merge sweeps, best-fit search, split, free
// depends on bba_pkg
`timescale 1ns / 1ps
module bba_ctrl
   import bba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     req,
   input  logic [32:0] need,
   output logic        need_load,
   output tbl_cmd_type cmd,
   input  slot_type    rd_data,
   output logic        busy,
   output logic        rsp_strobe,
   output rsp_type     rsp
);
   typedef enum logic [13:0] {
      S_CLEAR  = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_CHECK  = 14'b00000000000100,
      S_SW_RD  = 14'b00000000001000,
      S_SW_I   = 14'b00000000010000,
      S_SW_J   = 14'b00000000100000,
      S_FB_RD  = 14'b00000001000000,
      S_FB_CHK = 14'b00000010000000,
      S_SP_RD  = 14'b00000100000000,
      S_SP_CHK = 14'b00001000000000,
      S_FR_RD  = 14'b00010000000000,
      S_FR_CHK = 14'b00100000000000,
      S_DONE   = 14'b01000000000000,
      S_SP_UP  = 14'b10000000000000
   } state_type;

   // what to do after a sweep ends
   typedef enum logic [1:0] {
      AFT_FIND  = 2'd0,
      AFT_LOOP  = 2'd1,
      AFT_FIND2 = 2'd2
   } after_type;

   localparam int CntBits = SlotBits + 1;

   state_type            state_ff, state_in;
   logic [CntBits-1:0]   idx_ff, idx_in;
   logic [CntBits-1:0]   jdx_ff, jdx_in;
   slot_type             cur_ff, cur_in;
   logic                 merged_ff, merged_in;
   after_type            after_ff, after_in;
   logic                 best_ok_ff, best_ok_in;
   logic [SlotBits-1:0]  best_ff, best_in;
   logic [OrderBits-1:0] best_ord_ff, best_ord_in;
   logic                 func_ff;
   logic [15:0]          addr_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;

   logic [CntBits-1:0]   span;
   logic [47:0]          blk_bytes;
   logic [16:0]          off;

   assign span      = CntBits'(1) << cur_ff.order;
   assign blk_bytes = 48'(MinBlock) << rd_data.order;
   assign off       = 17'(addr_ff) - 17'(HeaderBytes);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         idx_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         strobe_ff  <= strobe_in;
      end
      jdx_ff      <= jdx_in;
      cur_ff      <= cur_in;
      merged_ff   <= merged_in;
      after_ff    <= after_in;
      best_ok_ff  <= best_ok_in;
      best_ff     <= best_in;
      best_ord_ff <= best_ord_in;
      rsp_ff      <= rsp_in;
      if (state_ff == S_IDLE && start) begin
         func_ff <= req.func;
         addr_ff <= req.address;
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      jdx_in      = jdx_ff;
      cur_in      = cur_ff;
      merged_in   = merged_ff;
      after_in    = after_ff;
      best_ok_in  = best_ok_ff;
      best_in     = best_ff;
      best_ord_in = best_ord_ff;
      rsp_in      = rsp_ff;
      strobe_in   = 1'b0;
      need_load   = 1'b0;
      cmd         = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_en         = 1'b1;
            cmd.wr_addr       = idx_ff[SlotBits-1:0];
            cmd.wr_data.free  = 1'b1;
            cmd.wr_data.start = (idx_ff == '0);
            cmd.wr_data.order = (idx_ff == '0) ? TopOrder : '0;
            idx_in = idx_ff + 1'b1;
            if (idx_ff[SlotBits-1:0] == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               need_load  = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            idx_in    = '0;
            merged_in = 1'b0;
            rsp_in    = '0;
            if (func_ff == FUNC_ALLOC) begin
               if (need > 33'(PoolBytes)) begin
                  rsp_in.status = ST_OOM;
                  state_in = S_DONE;
               end else begin
                  after_in = AFT_FIND;
                  state_in = S_SW_RD;
               end
            end else begin
               if (addr_ff < 16'(HeaderBytes) || off[MinShift-1:0] != '0 ||
                   off >= 17'(PoolBytes)) begin
                  rsp_in.status = ST_BAD;
                  state_in = S_DONE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = SlotBits'(off >> MinShift);
                  state_in    = S_FR_RD;
               end
            end
         end
         S_FR_RD: state_in = S_FR_CHK;
         S_FR_CHK: begin
            if (!rd_data.start) begin
               rsp_in.status = ST_BAD;
               state_in = S_DONE;
            end else begin
               cmd.wr_en        = 1'b1;
               cmd.wr_addr      = SlotBits'(off >> MinShift);
               cmd.wr_data      = rd_data;
               cmd.wr_data.free = 1'b1;
               after_in = AFT_LOOP;
               state_in = S_SW_RD;
            end
         end
         // sweep: read slot idx, then its buddy
         S_SW_RD: begin
            if (idx_ff >= CntBits'(NumSlots)) begin
               if (after_ff == AFT_LOOP && merged_ff) begin
                  idx_in = '0; merged_in = 1'b0;
               end else if (after_ff == AFT_LOOP) begin
                  if (func_ff == FUNC_FREE) begin
                     state_in = S_DONE;
                  end else begin
                     idx_in = '0; best_ok_in = 1'b0; after_in = AFT_FIND2;
                     state_in = S_FB_RD;
                  end
               end else begin
                  idx_in = '0; best_ok_in = 1'b0;
                  state_in = S_FB_RD;
               end
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = idx_ff[SlotBits-1:0];
               state_in    = S_SW_I;
            end
         end
         S_SW_I: begin
            cur_in = rd_data;
            if (!rd_data.start) begin
               idx_in = idx_ff + 1'b1;
               state_in = S_SW_RD;
            end else begin
               jdx_in = idx_ff + (CntBits'(1) << rd_data.order);
               if ((idx_ff & (CntBits'(1) << rd_data.order)) != '0 || !rd_data.free ||
                   idx_ff + (CntBits'(1) << rd_data.order) >= CntBits'(NumSlots)) begin
                  idx_in = idx_ff + (CntBits'(1) << rd_data.order);
                  state_in = S_SW_RD;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = SlotBits'(idx_ff + (CntBits'(1) << rd_data.order));
                  state_in    = S_SW_J;
               end
            end
         end
         S_SW_J: begin
            state_in = S_SW_RD;
            if (rd_data.start && rd_data.free && rd_data.order == cur_ff.order) begin
               // merge: clear buddy now, upper order written in S_SP_UP style below
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = jdx_ff[SlotBits-1:0];
               cmd.wr_data = '{order: '0, start: 1'b0, free: 1'b1};
               cur_in.order = cur_ff.order + 1'b1;
               merged_in = 1'b1;
               state_in  = S_SP_UP;
            end else begin
               idx_in = jdx_ff;
            end
         end
         S_SP_UP: begin
            // write merged head, then skip both halves
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = idx_ff[SlotBits-1:0];
            cmd.wr_data = cur_ff;
            idx_in      = idx_ff + (span << 0);
            state_in    = S_SW_RD;
         end
         // best-fit search
         S_FB_RD: begin
            if (idx_ff >= CntBits'(NumSlots)) begin
               if (best_ok_ff) begin
                  cmd.rd_en = 1'b1; cmd.rd_addr = best_ff;
                  state_in = S_SP_RD;
               end else if (after_ff == AFT_FIND) begin
                  idx_in = '0; merged_in = 1'b0; after_in = AFT_LOOP;
                  state_in = S_SW_RD;
               end else begin
                  rsp_in.status = ST_OOM;
                  state_in = S_DONE;
               end
            end else begin
               cmd.rd_en = 1'b1; cmd.rd_addr = idx_ff[SlotBits-1:0];
               state_in = S_FB_CHK;
            end
         end
         S_FB_CHK: begin
            state_in = S_FB_RD;
            if (!rd_data.start) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               if (rd_data.free && blk_bytes >= 48'(need) &&
                   (!best_ok_ff || rd_data.order < best_ord_ff)) begin
                  best_ok_in = 1'b1; best_in = idx_ff[SlotBits-1:0];
                  best_ord_in = rd_data.order;
               end
               idx_in = idx_ff + (CntBits'(1) << rd_data.order);
            end
         end
         S_SP_RD: begin
            cur_in = '0; cur_in.order = best_ord_ff;
            state_in = S_SP_CHK;
         end
         // split one level a cycle, keeping the upper half
         S_SP_CHK: begin
            if (cur_ff.order != '0 &&
                {need, 1'b0} < 34'(48'(MinBlock) << cur_ff.order)) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = best_ff;
               cmd.wr_data = '{order: cur_ff.order - 1'b1, start: 1'b1, free: 1'b1};
               best_in = best_ff + SlotBits'(CntBits'(1) << (cur_ff.order - 1'b1));
               cur_in.order = cur_ff.order - 1'b1;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = best_ff;
               cmd.wr_data = '{order: cur_ff.order, start: 1'b1, free: 1'b0};
               rsp_in.status = ST_OK;
               rsp_in.data_address = 16'(({16'd0, best_ff} << MinShift) + HeaderBytes);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;
endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// top level of the buddy block allocator
// depends on bba_pkg, bba_need, bba_table, bba_ctrl
`timescale 1ns / 1ps
// buddy allocator over a 64 KiB pool kept as a 2048-slot block table
// in one synchronous memory (order, start mark, free mark per slot)
// request channel: drive req_payload with start high; the transaction is
//    taken at a rising edge with start high and busy low
// func allocate: need = elem_size * item_count + header; one merge sweep,
//    best-fit search, split down, returns data address or out_of_memory;
//    on no fit, sweeps repeat until nothing merges, then one more search
// func free: checks the address, marks the block free, sweeps to fixpoint
// result channel: rsp_strobe high for exactly one cycle with rsp_payload;
//    the receiver cannot stall, busy stays high until the strobe cycle
// timing: each block visited in a search or a sweep costs a table read and
//    its check, a sweep also reads the buddy of a free head and writes the
//    buddy and the merged head when the pair merges, and split levels run
//    one per cycle; the total grows with each full sweep that runs, set by the
//    single table read port; one transaction at a time
// after reset a clearing pass writes all 2048 slots, one per cycle;
//    busy is high during the whole pass
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_payload,
   output logic    busy,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);
   tbl_cmd_type cmd;
   slot_type    rd_data;
   logic        need_load;
   logic [32:0] need;

   bba_need u_need (
      .clock      (clock),
      .load       (need_load),
      .elem_size  (req_payload.elem_size),
      .item_count (req_payload.item_count),
      .need       (need)
   );

   bba_table u_table (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   bba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req        (req_payload),
      .need       (need),
      .need_load  (need_load),
      .cmd        (cmd),
      .rd_data    (rd_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp_payload)
   );
endmodule

// ===== rtl/core/bba_checker.sv =====
// port-level checks for the buddy block allocator, bound to the top level
// depends on bba_pkg
`timescale 1ns / 1ps
module bba_checker
   import bba_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe longer than one cycle");
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_payload.status == ST_OK || rsp_payload.status == ST_OOM ||
                      rsp_payload.status == ST_BAD)) else $error("bad status");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status != ST_OK && rsp_payload.data_address != '0 |-> 1'b0)
      else $error("failed result with address");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transaction without busy");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("strobe while busy");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
